/* hw/rtl/hrb_pkg.sv */
// Package for the heightmap radial brush: request and direction codes,
// register indices, height limits and the sequencer state type.
// No dependencies.
package hrb_pkg;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_STROKE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [1:0] DIR_RAISE = 2'd1;
  localparam logic [1:0] DIR_LOWER = 2'd2;

  localparam logic [1:0] REG_GRID_WIDTH   = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_BRUSH_RADIUS = 2'd2;
  localparam logic [1:0] REG_STEP_AMOUNT  = 2'd3;

  localparam logic [8:0] GRID_WIDTH_RST   = 9'd256;
  localparam logic [8:0] GRID_HEIGHT_RST  = 9'd256;
  localparam logic [6:0] BRUSH_RADIUS_RST = 7'd10;
  localparam logic [9:0] STEP_AMOUNT_RST  = 10'd51;

  localparam logic [6:0] RADIUS_MAX = 7'd64;

  localparam logic signed [18:0] HEIGHT_MAX = 19'sh3FFFF;
  localparam logic signed [18:0] HEIGHT_MIN = -19'sh40000;

  // 3.0 in Q2.16
  localparam logic [17:0] SMOOTH_THREE = 18'd196608;

  localparam logic [4:0] DIV_STEPS  = 5'd23;
  localparam logic [3:0] SQRT_STEPS = 4'd15;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CHECK,
    ST_CDIV,
    ST_WIN,
    ST_CELL,
    ST_SQRT,
    ST_TDIV,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_RDC,
    ST_UPD,
    ST_NEXT,
    ST_RD,
    ST_RDW
  } state_t;

endpackage

/* hw/rtl/heightmap_radial_brush_unit.sv */
// Heightmap radial brush: height store, stroke sequencer with shared divider,
// square root and falloff multipliers, and the output register.
// Depends on hrb_pkg.
//
// One request is handled at a time. A load or a read passes through the
// LOAD, RD and RDW states, an ignored stroke through LOAD, CHECK, RD and RDW;
// the result register is loaded in RDW once the output is free, and the input
// is ready again in the cycle after that. A stroke first splits the
// centre index into row and column on the bit-serial divider, then walks the
// clipped window cell by cell: a cell outside the radius goes through CELL and
// NEXT only, a cell inside it also through the square root, the falloff
// division, three multiplier stages, and a read-modify-write of the height store.
// No clearing pass runs after reset: cells hold nothing defined until loaded.
module heightmap_radial_brush_unit #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // cell_index[15:0], height_value[34:16], stroke_dir[36:35], zero fill
  input  logic [39:0] s_tdata,
  // req_type[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // cell_height[18:0], height_code[34:19], min_height[53:35],
  // max_height[72:54], stroke_applied[73], zero fill
  output logic [79:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);
  import hrb_pkg::*;

  localparam int STORE_CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int AW = $clog2(STORE_CELLS);

  state_t state, state_next;

  logic [8:0] grid_width, grid_height;
  logic [6:0] brush_radius;
  logic [9:0] step_amount;
  logic [8:0] gw_c, gh_c;
  logic [6:0] r_c;

  logic [1:0]         req_type;
  logic [15:0]        idx;
  logic signed [18:0] hv;
  logic [1:0]         dir;

  logic signed [18:0] store [STORE_CELLS];
  logic signed [18:0] rdata;
  logic [AW-1:0]      raddr, waddr;
  logic               we;
  logic signed [18:0] wdata;

  logic signed [18:0] lowest, highest;
  logic               trk_en;

  logic [22:0] dv_num;
  logic [9:0]  dv_rem;
  logic [9:0]  dv_den;
  logic [4:0]  dv_cnt;
  logic [10:0] rem_sh;
  logic        dv_ge;

  logic [29:0] sx, sres, sbit;
  logic [3:0]  sq_cnt;
  logic [29:0] s_sum;

  logic signed [10:0] cx, cy, row, col, c0, c1, r1;
  logic signed [10:0] dx, dy;
  logic signed [15:0] dx2, dy2;
  logic [13:0]        sq;
  logic [13:0]        rr;

  logic [16:0] t, t2, smooth;
  logic [10:0] delta;
  logic [33:0] prod1;
  logic [34:0] prod2;
  logic [26:0] prod3;
  logic [17:0] fac;
  logic [14:0] num_t;

  logic               changed;
  logic signed [19:0] sum_h;
  logic signed [18:0] new_h;
  logic [19:0]        cell_lin;
  logic [31:0]        idx_w;
  logic               idx_in;
  logic [17:0]        area;
  logic               stroke_ok;
  logic               out_load;
  logic signed [18:0] res_h;
  logic signed [19:0] code_w;

  // Register clamps
  always_comb begin
    if (grid_width == 9'd0) gw_c = 9'd1;
    else if (int'(grid_width) > MAX_COLUMNS) gw_c = 9'(MAX_COLUMNS);
    else gw_c = grid_width;
    if (grid_height == 9'd0) gh_c = 9'd1;
    else if (int'(grid_height) > MAX_ROWS) gh_c = 9'(MAX_ROWS);
    else gh_c = grid_height;
    if (brush_radius == 7'd0) r_c = 7'd1;
    else if (brush_radius > RADIUS_MAX) r_c = RADIUS_MAX;
    else r_c = brush_radius;
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= GRID_WIDTH_RST;
      grid_height  <= GRID_HEIGHT_RST;
      brush_radius <= BRUSH_RADIUS_RST;
      step_amount  <= STEP_AMOUNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:   grid_width   <= cfg_data[8:0];
        REG_GRID_HEIGHT:  grid_height  <= cfg_data[8:0];
        REG_BRUSH_RADIUS: brush_radius <= cfg_data[6:0];
        REG_STEP_AMOUNT:  step_amount  <= cfg_data;
      endcase
    end
  end

  assign idx_w     = {16'd0, idx};
  assign idx_in    = idx_w < 32'(STORE_CELLS);
  assign area      = 18'(gw_c) * 18'(gh_c);
  assign stroke_ok = (idx != 16'd0) && ({2'b00, idx} < area) &&
                     ((dir == DIR_RAISE) || (dir == DIR_LOWER));

  // Shared restoring divider, one quotient bit per cycle
  assign rem_sh = {dv_rem, dv_num[22]};
  assign dv_ge  = rem_sh >= {1'b0, dv_den};

  // Digit-by-digit square root step
  assign s_sum = sres + sbit;

  // The offsets are signed, so they are squared at full signed width.
  assign dx  = col - cx;
  assign dy  = row - cy;
  assign dx2 = 16'(dx) * 16'(dx);
  assign dy2 = 16'(dy) * 16'(dy);
  assign sq  = 14'(16'(dx2) + 16'(dy2));
  assign rr  = 14'(r_c) * 14'(r_c);

  assign num_t = {r_c, 8'd0} - sres[14:0];
  assign prod1 = 34'(t) * 34'(t);
  assign fac   = SMOOTH_THREE - {t, 1'b0};
  assign prod2 = 35'(t2) * 35'(fac);
  assign prod3 = 27'(step_amount) * 27'(smooth);

  assign cell_lin = 20'(row[8:0]) * 20'(gw_c) + 20'(col[8:0]);

  always_comb begin
    if (dir == DIR_RAISE) sum_h = 20'(rdata) + $signed({9'd0, delta});
    else sum_h = 20'(rdata) - $signed({9'd0, delta});
    if (sum_h > 20'(HEIGHT_MAX)) new_h = HEIGHT_MAX;
    else if (sum_h < 20'(HEIGHT_MIN)) new_h = HEIGHT_MIN;
    else new_h = sum_h[18:0];
  end

  assign out_load = (state == ST_RDW) && (!m_tvalid || m_tready);
  assign s_tready = (state == ST_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    raddr      = idx_w[AW-1:0];
    waddr      = idx_w[AW-1:0];
    we         = 1'b0;
    wdata      = hv;
    trk_en     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        priority if (req_type == REQ_LOAD) begin
          we         = idx_in;
          trk_en     = idx_in;
          state_next = ST_RD;
        end else if (req_type == REQ_STROKE) begin
          state_next = ST_CHECK;
        end else begin
          state_next = ST_RD;
        end
      end
      ST_CHECK: state_next = stroke_ok ? ST_CDIV : ST_RD;
      ST_CDIV: if (dv_cnt == DIV_STEPS) state_next = ST_WIN;
      ST_WIN:  state_next = ST_CELL;
      ST_CELL: state_next = (sq > rr) ? ST_NEXT : ST_SQRT;
      ST_SQRT: if (sq_cnt == SQRT_STEPS) state_next = ST_TDIV;
      ST_TDIV: if (dv_cnt == DIV_STEPS) state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_MUL3;
      ST_MUL3: state_next = ST_RDC;
      ST_RDC: begin
        raddr      = cell_lin[AW-1:0];
        state_next = ST_UPD;
      end
      ST_UPD: begin
        waddr      = cell_lin[AW-1:0];
        wdata      = new_h;
        we         = 1'b1;
        trk_en     = 1'b1;
        state_next = ST_NEXT;
      end
      ST_NEXT: begin
        if (col == c1 && row == r1) state_next = ST_RD;
        else state_next = ST_CELL;
      end
      ST_RD:  state_next = ST_RDW;
      ST_RDW: if (out_load) state_next = ST_IDLE;
    endcase
  end

  // Height store
  always_ff @(posedge clk) begin
    if (we) store[waddr] <= wdata;
    rdata <= store[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lowest  <= HEIGHT_MAX;
      highest <= HEIGHT_MIN;
    end else if (trk_en) begin
      if (wdata < lowest) lowest <= wdata;
      if (wdata > highest) highest <= wdata;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          req_type <= s_tuser;
          idx      <= s_tdata[15:0];
          hv       <= s_tdata[34:16];
          dir      <= s_tdata[36:35];
        end
        changed <= 1'b0;
      end
      ST_CHECK: begin
        dv_num <= {7'd0, idx};
        dv_rem <= 10'd0;
        dv_den <= {1'b0, gw_c};
        dv_cnt <= 5'd0;
      end
      ST_CDIV, ST_TDIV: begin
        if (dv_cnt != DIV_STEPS) begin
          dv_num <= {dv_num[21:0], dv_ge};
          dv_rem <= dv_ge ? 10'(rem_sh - {1'b0, dv_den}) : rem_sh[9:0];
          dv_cnt <= dv_cnt + 5'd1;
        end else if (state == ST_CDIV) begin
          cy <= 11'(dv_num[8:0]);
          cx <= 11'(dv_rem[8:0]);
        end else begin
          t <= dv_num[16:0];
        end
      end
      ST_WIN: begin
        row <= (cy > 11'(r_c)) ? cy - 11'(r_c) : 11'sd0;
        col <= (cx > 11'(r_c)) ? cx - 11'(r_c) : 11'sd0;
        c0  <= (cx > 11'(r_c)) ? cx - 11'(r_c) : 11'sd0;
        r1  <= (cy + 11'(r_c) > 11'(gh_c) - 11'sd1) ? 11'(gh_c) - 11'sd1 : cy + 11'(r_c);
        c1  <= (cx + 11'(r_c) > 11'(gw_c) - 11'sd1) ? 11'(gw_c) - 11'sd1 : cx + 11'(r_c);
      end
      ST_CELL: begin
        sx     <= {sq, 16'd0};
        sres   <= 30'd0;
        sbit   <= 30'd1 << 28;
        sq_cnt <= 4'd0;
      end
      ST_SQRT: begin
        if (sq_cnt != SQRT_STEPS) begin
          if (sx >= s_sum) begin
            sx   <= sx - s_sum;
            sres <= (sres >> 1) + sbit;
          end else begin
            sres <= sres >> 1;
          end
          sbit   <= sbit >> 2;
          sq_cnt <= sq_cnt + 4'd1;
        end else begin
          dv_num <= {num_t, 8'd0};
          dv_rem <= 10'd0;
          dv_den <= {3'd0, r_c};
          dv_cnt <= 5'd0;
        end
      end
      ST_MUL1: t2     <= prod1[32:16];
      ST_MUL2: smooth <= prod2[32:16];
      ST_MUL3: delta  <= prod3[26:16];
      ST_UPD:  if (new_h != rdata) changed <= 1'b1;
      ST_NEXT: begin
        if (col == c1) begin
          col <= c0;
          row <= row + 11'sd1;
        end else begin
          col <= col + 11'sd1;
        end
      end
      default: ;
    endcase
  end

  // Result register
  assign res_h  = idx_in ? rdata : 19'sd0;
  assign code_w = (20'(res_h) + (res_h[18] ? 20'sd7 : 20'sd0)) >>> 3;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {6'd0, (req_type == REQ_STROKE) && changed, highest, lowest,
                  code_w[15:0], res_h};
    end
  end

endmodule

/* hw/rtl/hrb_checker.sv */
// Port-level checker for the heightmap radial brush, with its bind.
// Depends on heightmap_radial_brush_unit's ports only.
module hrb_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata
);
  logic signed [18:0] h, lo, hi;
  logic signed [15:0] code;

  assign h    = m_tdata[18:0];
  assign code = m_tdata[34:19];
  assign lo   = m_tdata[53:35];
  assign hi   = m_tdata[72:54];

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result transaction changed");

  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> code == 16'(h / 19'sd8))
    else $error("height code does not match height");

  a_applied: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[73] |-> lo <= h && h <= hi)
    else $error("stroke result outside tracked range");

endmodule

bind heightmap_radial_brush_unit hrb_checker u_hrb_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
